// File: hdl/vital_sign_alarm_qualifier_top_defines.svh
// Assertion macros for the vital-sign alarm qualifier.
// Define NO_ASSERTIONS to compile the checks away.
`ifndef VITAL_SIGN_ALARM_QUALIFIER_TOP_DEFINES_SVH
`define VITAL_SIGN_ALARM_QUALIFIER_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS

// The consequent must hold in the same cycle as the antecedent.
`define VSAQ_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define VSAQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define VSAQ_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define VSAQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// File: hdl/vsaq_pkg.sv
package vsaq_pkg;

    // Detector register layout.
    localparam int CFG_COUNT = 8;
    localparam int CFG_W     = 43;
    localparam int CFG_IDX_W = 3;
    localparam int TYPE_LSB  = 0;
    localparam int TYPE_MSB  = 2;
    localparam int THR_LSB   = 3;
    localparam int THR_MSB   = 18;
    localparam int HYS_LSB   = 19;
    localparam int HYS_MSB   = 34;
    localparam int DEB_LSB   = 35;
    localparam int DEB_MSB   = 42;

    // Result field widths.
    localparam int TYPE_W  = 3;
    localparam int COUNT_W = 4;
    localparam int TOTAL_W = 32;
    localparam int DEB_W   = 8;
    localparam int THR_W   = 16;

    // Alarm type codes.
    localparam logic [TYPE_W-1:0] TYPE_NONE     = 3'd0;
    localparam logic [TYPE_W-1:0] TYPE_APNEA    = 3'd1;
    localparam logic [TYPE_W-1:0] TYPE_FAST_HR  = 3'd3;
    localparam logic [TYPE_W-1:0] TYPE_SLOW_HR  = 3'd4;
    localparam logic [TYPE_W-1:0] TYPE_RESTLESS = 3'd6;
    localparam logic [TYPE_W-1:0] TYPE_LOW_SPO2 = 3'd7;

    // Detector settings after reset.
    localparam logic [CFG_W-1:0] DET_RESET [CFG_COUNT] = '{
        43'd103095993601, 43'd103121170947, 43'd103121163268, 43'd103096003847,
        43'd0, 43'd0, 43'd0, 43'd0
    };

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic step;
        logic next;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_more;
        logic last_item;
    } t_status;

endpackage

// File: hdl/vsaq_ctrl.sv
module vsaq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    input  vsaq_pkg::t_status i_status,
    output vsaq_pkg::t_cmd    o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } t_state;

    t_state r_state;
    logic   r_in_stall;
    logic   r_out_valid;
    logic   w_in_acc;
    logic   w_out_acc;

    // Handshake completions.
    assign w_in_acc  = i_in_valid && !r_in_stall;
    assign w_out_acc = r_out_valid && !i_out_stall;

    // Commands to the datapath.
    always_comb begin
        o_cmd.load = (r_state == ST_IDLE) && w_in_acc;
        o_cmd.step = (r_state == ST_SCAN) && i_status.scan_more;
        o_cmd.next = (r_state == ST_EMIT) && w_out_acc && !i_status.last_item;
    end

    assign o_in_stall  = r_in_stall;
    assign o_out_valid = r_out_valid;

    // State and registered handshake outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_in_stall  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (w_in_acc) begin
                        r_state    <= ST_SCAN;
                        r_in_stall <= 1'b1;
                    end
                end
                ST_SCAN: begin
                    if (!i_status.scan_more) begin
                        r_state     <= ST_EMIT;
                        r_out_valid <= 1'b1;
                    end
                end
                ST_EMIT: begin
                    if (w_out_acc && i_status.last_item) begin
                        r_state     <= ST_IDLE;
                        r_out_valid <= 1'b0;
                        r_in_stall  <= 1'b0;
                    end
                end
                default: begin
                    r_state     <= ST_IDLE;
                    r_out_valid <= 1'b0;
                    r_in_stall  <= 1'b0;
                end
            endcase
        end
    end

endmodule

// File: hdl/vsaq_dp.sv
module vsaq_dp #(
    parameter int NUM_DETECTORS = 8,
    parameter int VALUE_BITS    = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  vsaq_pkg::t_cmd                      i_cmd,
    output vsaq_pkg::t_status                   o_status,
    input  logic                                i_cfg_we,
    input  logic [vsaq_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [vsaq_pkg::CFG_W-1:0]          i_cfg_data,
    input  logic                                i_func,
    input  logic [VALUE_BITS-1:0]               i_pulse_rate,
    input  logic [VALUE_BITS-1:0]               i_breath_rate,
    input  logic [VALUE_BITS-1:0]               i_oxygen_saturation,
    input  logic [VALUE_BITS-1:0]               i_motion_level,
    input  logic [vsaq_pkg::COUNT_W-1:0]        i_result_cap,
    output logic [vsaq_pkg::TYPE_W-1:0]         o_alarm_type,
    output logic                                o_last,
    output logic [vsaq_pkg::COUNT_W-1:0]        o_raised_count,
    output logic [vsaq_pkg::COUNT_W-1:0]        o_latched_count,
    output logic [vsaq_pkg::TOTAL_W-1:0]        o_alarm_tally
);

    localparam int SW   = (NUM_DETECTORS > 1) ? $clog2(NUM_DETECTORS) : 1;
    localparam int CNTW = $clog2(NUM_DETECTORS + 1);
    localparam int CW   = ((VALUE_BITS > vsaq_pkg::THR_W) ? VALUE_BITS : vsaq_pkg::THR_W) + 2;
    localparam int CIW  = vsaq_pkg::CFG_IDX_W + 1;

    // Detector settings and per-slot state.
    logic [vsaq_pkg::CFG_W-1:0]   r_det   [NUM_DETECTORS];
    logic                         r_lat   [NUM_DETECTORS];
    logic [vsaq_pkg::DEB_W-1:0]   r_cnt   [NUM_DETECTORS];
    logic [vsaq_pkg::TOTAL_W-1:0] r_total;
    logic [vsaq_pkg::COUNT_W-1:0] r_active;

    // Scan and emit bookkeeping.
    logic [CNTW-1:0]              r_slot;
    logic [vsaq_pkg::COUNT_W-1:0] r_raised;
    logic [SW-1:0]                r_emit;

    // Captured item and raised-type buffer.
    logic                         r_func;
    logic [VALUE_BITS-1:0]        r_hr;
    logic [VALUE_BITS-1:0]        r_rr;
    logic [VALUE_BITS-1:0]        r_sp;
    logic [VALUE_BITS-1:0]        r_mv;
    logic [vsaq_pkg::COUNT_W-1:0] r_cap;
    logic [vsaq_pkg::TYPE_W-1:0]  r_buf [NUM_DETECTORS];

    // Slot evaluation signals.
    logic [SW-1:0]                w_idx;
    logic [vsaq_pkg::CFG_W-1:0]   w_det;
    logic [vsaq_pkg::TYPE_W-1:0]  w_type;
    logic [vsaq_pkg::DEB_W-1:0]   w_deb;
    logic signed [CW-1:0]         w_thr;
    logic signed [CW-1:0]         w_hys;
    logic signed [CW-1:0]         w_up;
    logic signed [CW-1:0]         w_dn;
    logic signed [CW-1:0]         w_hr;
    logic signed [CW-1:0]         w_rr;
    logic signed [CW-1:0]         w_sp;
    logic signed [CW-1:0]         w_mv;
    logic                         w_hit;
    logic                         w_back;
    logic [vsaq_pkg::DEB_W-1:0]   n_cnt;
    logic                         w_cfg_ok;

    // Field decode of the slot under scan.
    assign w_idx  = r_slot[SW-1:0];
    assign w_det  = r_det[w_idx];
    assign w_type = w_det[vsaq_pkg::TYPE_MSB:vsaq_pkg::TYPE_LSB];
    assign w_deb  = w_det[vsaq_pkg::DEB_MSB:vsaq_pkg::DEB_LSB];
    assign w_thr  = CW'(w_det[vsaq_pkg::THR_MSB:vsaq_pkg::THR_LSB]);
    assign w_hys  = CW'(w_det[vsaq_pkg::HYS_MSB:vsaq_pkg::HYS_LSB]);
    assign w_up   = w_thr + w_hys;
    assign w_dn   = w_thr - w_hys;
    assign w_hr   = CW'(r_hr);
    assign w_rr   = CW'(r_rr);
    assign w_sp   = CW'(r_sp);
    assign w_mv   = CW'(r_mv);
    assign n_cnt  = r_cnt[w_idx] + 8'd1;

    // Type-specific trigger and recovery compares.
    always_comb begin
        case (w_type)
            vsaq_pkg::TYPE_APNEA: begin
                w_hit  = (w_rr > 0) && (w_rr < w_thr);
                w_back = (w_rr >= w_up);
            end
            vsaq_pkg::TYPE_FAST_HR: begin
                w_hit  = (w_hr > w_thr);
                w_back = (w_hr <= w_dn);
            end
            vsaq_pkg::TYPE_SLOW_HR: begin
                w_hit  = (w_hr > 0) && (w_hr < w_thr);
                w_back = (w_hr >= w_up);
            end
            vsaq_pkg::TYPE_RESTLESS: begin
                w_hit  = (w_mv > w_thr);
                w_back = 1'b1;
            end
            vsaq_pkg::TYPE_LOW_SPO2: begin
                w_hit  = (w_sp > 0) && (w_sp < w_thr);
                w_back = (w_sp >= w_up);
            end
            default: begin
                w_hit  = 1'b0;
                w_back = 1'b1;
            end
        endcase
    end

    // The scan goes on while slots remain and the cap is not reached, and never for a clear command.
    assign o_status.scan_more = !r_func && (r_slot < CNTW'(NUM_DETECTORS)) && (r_raised < r_cap);
    assign o_status.last_item = (r_raised == '0) ||
                                ((vsaq_pkg::COUNT_W'(r_emit) + 4'd1) == r_raised);

    // Result fields; the type and last flag follow the result on offer, the counts hold.
    assign o_alarm_type    = (r_raised == '0) ? vsaq_pkg::TYPE_NONE : r_buf[r_emit];
    assign o_last          = o_status.last_item;
    assign o_raised_count  = r_raised;
    assign o_latched_count = r_active;
    assign o_alarm_tally   = r_total;

    assign w_cfg_ok = (CIW'(i_cfg_index) < CIW'(NUM_DETECTORS));

    // Settings, detector state and sequencing counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_DETECTORS; k++) begin
                r_det[k] <= vsaq_pkg::DET_RESET[k];
                r_lat[k] <= 1'b0;
                r_cnt[k] <= '0;
            end
            r_total  <= '0;
            r_active <= '0;
            r_slot   <= '0;
            r_raised <= '0;
            r_emit   <= '0;
        end else begin
            if (i_cfg_we && w_cfg_ok) begin
                r_det[i_cfg_index[SW-1:0]] <= i_cfg_data;
            end
            if (i_cmd.load) begin
                r_slot   <= '0;
                r_raised <= '0;
                r_emit   <= '0;
                if (i_func) begin
                    for (int k = 0; k < NUM_DETECTORS; k++) begin
                        r_lat[k] <= 1'b0;
                        r_cnt[k] <= '0;
                    end
                    r_active <= '0;
                end
            end else if (i_cmd.step) begin
                r_slot <= r_slot + CNTW'(1);
                if (w_hit && !r_lat[w_idx]) begin
                    if (n_cnt >= w_deb) begin
                        r_lat[w_idx] <= 1'b1;
                        r_cnt[w_idx] <= '0;
                        r_total      <= r_total + 32'd1;
                        r_raised     <= r_raised + 4'd1;
                        r_active     <= r_active + 4'd1;
                    end else begin
                        r_cnt[w_idx] <= n_cnt;
                    end
                end else if (!w_hit && r_lat[w_idx]) begin
                    if (w_back) begin
                        r_lat[w_idx] <= 1'b0;
                        r_cnt[w_idx] <= '0;
                        r_active     <= r_active - 4'd1;
                    end
                end else if (!w_hit) begin
                    r_cnt[w_idx] <= '0;
                end
            end else if (i_cmd.next) begin
                r_emit <= r_emit + SW'(1);
            end
        end
    end

    // Item capture and the list of raised types.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func <= i_func;
            r_hr   <= i_pulse_rate;
            r_rr   <= i_breath_rate;
            r_sp   <= i_oxygen_saturation;
            r_mv   <= i_motion_level;
            r_cap  <= i_result_cap;
        end
        if (i_cmd.step && w_hit && !r_lat[w_idx] && (n_cnt >= w_deb)) begin
            r_buf[r_raised[SW-1:0]] <= w_type;
        end
    end

endmodule

// File: hdl/vital_sign_alarm_qualifier_top.sv
// Vital-sign alarm qualifier.
// Input channel (i_in_valid / o_in_stall) takes one item: a command bit, four
// vital signs and a cap on raised alarms. Output channel (o_out_valid /
// i_out_stall) gives one or more result items per input; the last carries
// o_last. Detector slots are set through a plain write port (i_cfg_we,
// i_cfg_index, i_cfg_data); the user must write them only while the block is
// idle, and the block itself does not enforce this. An input item is taken,
// then the shared slot evaluator scans one detector slot per cycle, covering
// NUM_DETECTORS slots (fewer when the cap is reached, none for a clear). The
// first result is registered when the scan ends; the results are then offered
// in turn, and the input reopens in the cycle after the last result is taken.
// A clear command clears latches and debounce counts and returns one result.
// Reset restores the default detector settings, clears all latches, counts and
// the running total, and leaves both channels empty.
// While the receiver stalls, the current result holds and no new item is taken.

`include "vital_sign_alarm_qualifier_top_defines.svh"

module vital_sign_alarm_qualifier_top #(
    parameter int NUM_DETECTORS = 8,
    parameter int VALUE_BITS    = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_func,
    input  logic [VALUE_BITS-1:0]               i_pulse_rate,
    input  logic [VALUE_BITS-1:0]               i_breath_rate,
    input  logic [VALUE_BITS-1:0]               i_oxygen_saturation,
    input  logic [VALUE_BITS-1:0]               i_motion_level,
    input  logic [vsaq_pkg::COUNT_W-1:0]        i_result_cap,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [vsaq_pkg::TYPE_W-1:0]         o_alarm_type,
    output logic                                o_last,
    output logic [vsaq_pkg::COUNT_W-1:0]        o_raised_count,
    output logic [vsaq_pkg::COUNT_W-1:0]        o_latched_count,
    output logic [vsaq_pkg::TOTAL_W-1:0]        o_alarm_tally,
    input  logic                                i_cfg_we,
    input  logic [vsaq_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [vsaq_pkg::CFG_W-1:0]          i_cfg_data
);

    vsaq_pkg::t_cmd    w_cmd;
    vsaq_pkg::t_status w_status;
    logic              w_in_take;
    logic              w_out_done;
    logic              w_out_more;
    logic              w_empty_out;
    logic              w_empty_form;

    // Sequencer for load, scan and emit.
    vsaq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    // Detector settings, slot evaluator and result registers.
    vsaq_dp #(
        .NUM_DETECTORS (NUM_DETECTORS),
        .VALUE_BITS    (VALUE_BITS)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (w_cmd),
        .o_status            (w_status),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_func              (i_func),
        .i_pulse_rate        (i_pulse_rate),
        .i_breath_rate       (i_breath_rate),
        .i_oxygen_saturation (i_oxygen_saturation),
        .i_motion_level      (i_motion_level),
        .i_result_cap        (i_result_cap),
        .o_alarm_type        (o_alarm_type),
        .o_last              (o_last),
        .o_raised_count      (o_raised_count),
        .o_latched_count     (o_latched_count),
        .o_alarm_tally       (o_alarm_tally)
    );

    // Handshake terms used by the checks below.
    assign w_in_take    = i_in_valid && !o_in_stall;
    assign w_out_done   = o_out_valid && !i_out_stall && o_last;
    assign w_out_more   = o_out_valid && !i_out_stall && !o_last;
    assign w_empty_out  = o_out_valid && (o_raised_count == '0);
    assign w_empty_form = o_last && (o_alarm_type == vsaq_pkg::TYPE_NONE);

    // A new item is never taken while results of the previous one are pending.
    `VSAQ_ASSERT_SAME(a_no_overlap, i_clk, i_rst_n, w_in_take, !o_out_valid, "overlapping items")
    // Taking the last result ends the output burst.
    `VSAQ_ASSERT_NEXT(a_last_ends, i_clk, i_rst_n, w_out_done, !o_out_valid, "burst overran")
    // Taking a result that is not the last leaves another one on offer.
    `VSAQ_ASSERT_NEXT(a_burst_goes_on, i_clk, i_rst_n, w_out_more, o_out_valid, "burst broken")
    // An item that raises nothing gives a single empty result.
    `VSAQ_ASSERT_SAME(a_empty_result, i_clk, i_rst_n, w_empty_out, w_empty_form, "bad empty result")

endmodule
